### src/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

  typedef enum logic [1:0] {
    OP_DATA     = 2'd0,
    OP_DATA_END = 2'd1,
    OP_END      = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // Entry passed from the front end to the engine through the queue
  typedef struct packed {
    logic       has_byte;
    logic       ends_msg;
    logic [7:0] data;
  } cmd_t;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } eng_state_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

### src/sha_front.sv
// Front end: accepts input transfers, drops unused codes and queues commands.
module sha_front #(
  parameter int QDEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [7:0]    in_data_byte,
  output logic          q_valid,
  input  logic          q_ready,
  output sha_pkg::cmd_t q_cmd
);
  import sha_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_t             mem_r [QDEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             push, pop;
  cmd_t             cmd;

  // Classify the incoming op
  always_comb begin
    cmd = '0;
    cmd.data = in_data_byte;
    unique case (op_t'(in_op))
      OP_DATA:     cmd.has_byte = 1'b1;
      OP_DATA_END: begin
        cmd.has_byte = 1'b1;
        cmd.ends_msg = 1'b1;
      end
      OP_END:      cmd.ends_msg = 1'b1;
      default:     cmd = '0;
    endcase
  end

  assign in_ready = (cnt_r != (AW+1)'(QDEPTH));
  assign push     = in_valid && in_ready && (cmd.has_byte || cmd.ends_msg);
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem_r[rp_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

### src/sha_engine.sv
// Engine: block buffer, one-round-per-cycle compression, padding and digest output.
module sha_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  sha_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_digest_word,
  output logic [2:0]    out_word_index,
  output logic          out_last_word
);
  import sha_pkg::*;

  eng_state_t  state_r, state_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [63:0] bits_r;
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic        fin_r;   // padding of the current message is under way
  logic        mark_r;  // 0x80 marker placed
  logic        wrap_r;  // marker landed at offset 56 to 62, length goes in the next block
  logic        cnt_r;   // length bytes placed

  // Byte that enters the buffer this cycle
  logic        take;
  logic [7:0]  tbyte;
  logic [31:0] t1, t2, wnew, wcur;

  always_comb begin
    take  = 1'b0;
    tbyte = q_cmd.data;
    q_ready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (q_cmd.has_byte) begin
            take = 1'b1;
            if (q_cmd.ends_msg) state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD: state_nxt = fin_r ? ((cnt_r) ? ST_EMIT : ST_PAD) : ST_IDLE;
      ST_PAD: begin
        take = 1'b1;
        if (!mark_r) begin
          tbyte = PAD_BYTE;
        end else if (fill_r >= 6'd56 && !wrap_r) begin
          tbyte = bits_r[8'd63 - {fill_r[2:0], 3'b0} -: 8];
        end else begin
          tbyte = 8'h00;
        end
      end
      ST_EMIT: if (out_ready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    // A full block goes to compression
    if (take && fill_r == 6'd63) state_nxt = ST_ROUND;
  end

  // Message schedule word of the current round and the round sums
  assign wcur = w_r[0];
  assign wnew = w_r[0] + sig0(w_r[1]) + w_r[9] + sig1(w_r[14]);
  assign t1   = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
              + ROUND_K[rnd_r] + wcur;
  assign t2   = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      wrap_r  <= 1'b0;
      cnt_r   <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
    end else begin
      state_r <= state_nxt;
      // Byte insertion into the word buffer
      if (take) begin
        w_r[fill_r[5:2]] <= {w_r[fill_r[5:2]][23:0], tbyte};
        fill_r <= fill_r + 6'd1;
        if (state_r == ST_IDLE) begin
          bits_r <= bits_r + 64'd8;
          fin_r  <= q_cmd.ends_msg;
        end else begin
          fin_r <= 1'b1;
          if (!mark_r) begin
            mark_r <= 1'b1;
            wrap_r <= (fill_r >= 6'd56) && (fill_r != 6'd63);
          end else if (fill_r == 6'd63) begin
            wrap_r <= 1'b0;
          end
          if (fill_r == 6'd63 && mark_r && !wrap_r) cnt_r <= 1'b1;
        end
        if (fill_r == 6'd63) begin
          rnd_r   <= '0;
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
      end
      if (state_r == ST_IDLE && q_valid && !q_cmd.has_byte) begin
        fin_r <= 1'b1;
      end
      // Compression round
      if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wnew;
        v_r[0] <= t1 + t2;
        v_r[1] <= v_r[0];
        v_r[2] <= v_r[1];
        v_r[3] <= v_r[2];
        v_r[4] <= v_r[3] + t1;
        v_r[5] <= v_r[4];
        v_r[6] <= v_r[5];
        v_r[7] <= v_r[6];
      end
      if (state_r == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      // Digest output, then return to the initial state
      if (state_r == ST_EMIT && out_ready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= INIT_H[i];
          bits_r <= '0;
          fin_r  <= 1'b0;
          mark_r <= 1'b0;
          wrap_r <= 1'b0;
          cnt_r  <= 1'b0;
        end
      end
    end
  end

  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

endmodule

### src/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher.
// Usage:
//   in_ channel: one transfer per message byte. in_op 0 is a data byte,
//   1 a data byte that ends the message, 2 ends the message with no byte,
//   3 is dropped. in_data_byte is ignored for op 2.
//   out_ channel: eight transfers per message, digest words most
//   significant first, with out_word_index and out_last_word.
// Timing:
//   A command queue decouples the byte intake from the engine. The engine
//   absorbs one byte per cycle while idle; every 64th byte starts a
//   compression of 64 rounds, one per cycle, then the hash update; no byte
//   is taken meanwhile. End of message adds padding bytes at one per cycle
//   and one or two more compressions, then the digest words at one per
//   cycle while out_ready is high.
// Reset:
//   rst_n clears the queue, bit count and fill count and loads the
//   initial hash values.
// Stalls:
//   While out_ready is low the engine holds the current digest word; the
//   queue keeps taking bytes until it is full, then in_ready drops.
module sha256_stream_hasher #(
  parameter int QDEPTH = sha_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;

  sha_front #(.QDEPTH(QDEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_data_byte,
    .q_valid, .q_ready, .q_cmd
  );

  sha_engine u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
  );

endmodule

### src/sha_checker.sv
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // Last flag marks word seven only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // Words of a digest follow in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest words out of order");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_digest_word)
      && $stable(out_word_index)))
    else $error("stalled result changed");

  // No output straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sha256_stream_hasher sha_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_digest_word, .out_word_index,
  .out_last_word
);
